// ===== hdl/jasct_pkg.sv =====
// Types, codes and arithmetic helpers of the joint angle slew clamp table.
package jasct_pkg;

  localparam int FullTurn = 92160;
  localparam int TurnMax  = 11;

  localparam logic [2:0] MODE_LOAD = 3'd0;
  localparam logic [2:0] MODE_ROT  = 3'd1;
  localparam logic [2:0] MODE_SLEW = 3'd2;
  localparam logic [2:0] MODE_MOVE = 3'd3;
  localparam logic [2:0] MODE_TOG  = 3'd4;
  localparam logic [2:0] MODE_ALL  = 3'd5;
  localparam logic [2:0] MODE_NONE = 3'd6;
  localparam logic [2:0] MODE_READ = 3'd7;

  localparam logic [1:0] AXIS_NONE = 2'd3;

  typedef struct packed {
    logic [2:0][19:0] ang;
    logic [2:0][19:0] lo;
    logic [2:0][19:0] hi;
  } row_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CALC,
    ST_WRAP,
    ST_WR,
    ST_ORD,
    ST_OUT
  } state_e;

  // truncating remainder by a full turn, |v| <= 2^20
  function automatic logic signed [19:0] wrap_turn(input logic signed [20:0] v);
    logic [20:0] a;
    logic [3:0]  q;
    logic [20:0] r;
    logic [20:0] res;
    a = v[20] ? 21'(-v) : 21'(v);
    q = 4'd0;
    for (int i = 1; i <= TurnMax; i++) begin
      if (a >= 21'(i * FullTurn)) q = 4'(i);
    end
    r = a - 21'(q * 21'(FullTurn));
    res = v[20] ? 21'(-r) : r;
    return res[19:0];
  endfunction

  function automatic logic signed [20:0] ext(input logic [19:0] v);
    return $signed({v[19], v});
  endfunction

  // maximum first, then minimum
  function automatic logic [19:0] clamp_hl(input logic signed [20:0] v,
                                           input logic [19:0] lo,
                                           input logic [19:0] hi);
    logic signed [20:0] r;
    r = v;
    if (r > ext(hi)) r = ext(hi);
    if (r < ext(lo)) r = ext(lo);
    return r[19:0];
  endfunction

  // minimum first, then maximum
  function automatic logic [19:0] clamp_lh(input logic signed [20:0] v,
                                           input logic [19:0] lo,
                                           input logic [19:0] hi);
    logic signed [20:0] r;
    r = v;
    if (r < ext(lo)) r = ext(lo);
    if (r > ext(hi)) r = ext(hi);
    return r[19:0];
  endfunction

  function automatic logic signed [20:0] slew(input logic [19:0] cur,
                                              input logic [19:0] tgt,
                                              input logic [18:0] step);
    logic signed [20:0] d;
    logic [20:0]        mag;
    logic signed [20:0] s;
    logic signed [20:0] r;
    d   = ext(cur) - ext(tgt);
    mag = d[20] ? 21'(-d) : 21'(d);
    s   = $signed({2'b00, step});
    if (mag > 21'(s)) begin
      r = (d > 0) ? ext(cur) - s : ext(cur) + s;
    end else begin
      r = ext(tgt);
    end
    return r;
  endfunction

endpackage

// ===== hdl/joint_angle_slew_clamp_table_unit.sv =====
// Joint angle table with slew, clamp, wrap and selection commands.
//
// One item at a time. Read, toggle, select all/none and any item that
// leaves the table alone pass ORD and OUT before valid_o strobes; load,
// rotate and slew place first pass CALC, WRAP and WR, the read-modify-
// write of one joint row in the one-read, one-write table memory. Move
// selected walks every joint, with CALC, WRAP and WR per selected joint.
// busy falls in the cycle the result is shown, so the next item may start
// then. The receiver cannot stall; each result is shown for one cycle only.
module joint_angle_slew_clamp_table_unit #(
  parameter int JOINT_COUNT = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         mode_i,
  input  logic [4:0]         joint_i,
  input  logic [1:0]         axis_i,
  input  logic signed [19:0] value_x_i,
  input  logic signed [19:0] value_y_i,
  input  logic signed [19:0] value_z_i,
  input  logic [18:0]        step_i,
  output logic               valid_o,
  output logic signed [19:0] angle_o,
  output logic               is_selected_o,
  output logic               changed_o
);
  import jasct_pkg::*;

  localparam int IW = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;

  row_t   mem [JOINT_COUNT];
  row_t   rdata_q;
  logic   rvld_q;
  logic [JOINT_COUNT-1:0] vld_q, sel_q;

  state_e state_q, state_d;
  logic [2:0]  mode_q;
  logic [1:0]  axis_q;
  logic [19:0] vx_q, vy_q, vz_q;
  logic [18:0] step_q;
  logic [IW-1:0] row_q, cnt_q, cnt_d, raddr, waddr;
  logic        jvld_q, jvld_in, single_in, accept, wr_en, last;

  logic signed [20:0] pre_q [3];
  logic signed [20:0] pre_d [3];
  logic [2:0]  wm_q, wm_d;
  logic [2:0][19:0] lo_q, hi_q, lo_d, hi_d;
  logic        chg_q, chg_d;
  row_t        rd_row, wrow_q;

  logic        valid_q, sel_out_q, chg_out_q;
  logic [19:0] ang_out_q;

  assign accept    = start && !busy;
  assign busy      = (state_q != ST_IDLE);
  assign jvld_in   = ({4'b0, joint_i} < 9'(JOINT_COUNT));
  assign single_in = jvld_in && ((((mode_i == MODE_LOAD) || (mode_i == MODE_ROT)) &&
                     (axis_i != AXIS_NONE)) || (mode_i == MODE_SLEW));
  assign last      = (cnt_q == IW'(JOINT_COUNT - 1));
  assign rd_row    = rvld_q ? rdata_q : '0;
  assign wr_en     = (state_q == ST_WR);
  assign waddr     = (mode_q == MODE_MOVE) ? cnt_q : row_q;

  always_comb begin
    unique case (state_q)
      ST_IDLE: raddr = IW'(joint_i);
      ST_SCAN: raddr = cnt_q;
      default: raddr = row_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr];
    if (wr_en) begin
      mem[waddr] <= wrow_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rvld_q <= 1'b0;
      vld_q  <= '0;
      sel_q  <= '0;
    end else begin
      rvld_q <= vld_q[raddr];
      if (wr_en) vld_q[waddr] <= 1'b1;
      if (accept) begin
        unique case (mode_i)
          MODE_TOG:  if (jvld_in) sel_q[IW'(joint_i)] <= !sel_q[IW'(joint_i)];
          MODE_ALL:  sel_q <= '1;
          MODE_NONE: sel_q <= '0;
          default:   ;
        endcase
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pre_d[k] = ext(rd_row.ang[k]);
    end
    wm_d  = '0;
    lo_d  = rd_row.lo;
    hi_d  = rd_row.hi;
    chg_d = 1'b0;
    unique case (mode_q)
      MODE_LOAD: if (axis_q != AXIS_NONE) begin
        pre_d[axis_q] = ext(vx_q);
        lo_d[axis_q]  = vy_q;
        hi_d[axis_q]  = vz_q;
      end
      MODE_ROT: if (axis_q != AXIS_NONE) begin
        pre_d[axis_q] = ext(rd_row.ang[axis_q]) + ext(vx_q);
        wm_d[axis_q]  = 1'b1;
      end
      MODE_SLEW: begin
        pre_d[0] = ext(clamp_hl(slew(rd_row.ang[0], vx_q, step_q),
                                rd_row.lo[0], rd_row.hi[0]));
        pre_d[1] = ext(clamp_hl(slew(rd_row.ang[1], vy_q, step_q),
                                rd_row.lo[1], rd_row.hi[1]));
        pre_d[2] = ext(clamp_lh(slew(rd_row.ang[2], vz_q, step_q),
                                rd_row.lo[2], rd_row.hi[2]));
        for (int k = 0; k < 3; k++) begin
          if (pre_d[k] != ext(rd_row.ang[k])) chg_d = 1'b1;
        end
      end
      MODE_MOVE: begin
        pre_d[0] = ext(clamp_hl(ext(rd_row.ang[0]) + ext(vx_q),
                                rd_row.lo[0], rd_row.hi[0]));
        pre_d[1] = ext(clamp_hl(ext(rd_row.ang[1]) + ext(vy_q),
                                rd_row.lo[1], rd_row.hi[1]));
        wm_d = 3'b111;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: if (accept) begin
        cnt_d = '0;
        if (mode_i == MODE_MOVE) state_d = ST_SCAN;
        else if (single_in)      state_d = ST_CALC;
        else                     state_d = ST_ORD;
      end
      ST_SCAN: begin
        if (sel_q[cnt_q]) state_d = ST_CALC;
        else if (last)    state_d = ST_ORD;
        else              cnt_d   = cnt_q + 1'b1;
      end
      ST_CALC: state_d = ST_WRAP;
      ST_WRAP: state_d = ST_WR;
      ST_WR: begin
        if (mode_q != MODE_MOVE || last) begin
          state_d = ST_ORD;
        end else begin
          state_d = ST_SCAN;
          cnt_d   = cnt_q + 1'b1;
        end
      end
      ST_ORD:  state_d = ST_OUT;
      ST_OUT:  state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      valid_q <= 1'b0;
      chg_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      valid_q <= (state_q == ST_OUT);
      if (accept) chg_q <= 1'b0;
      else if (state_q == ST_CALC) chg_q <= chg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q <= mode_i;
      axis_q <= axis_i;
      vx_q   <= value_x_i;
      vy_q   <= value_y_i;
      vz_q   <= value_z_i;
      step_q <= step_i;
      row_q  <= IW'(joint_i);
      jvld_q <= jvld_in;
    end
    if (state_q == ST_CALC) begin
      pre_q <= pre_d;
      wm_q  <= wm_d;
      lo_q  <= lo_d;
      hi_q  <= hi_d;
    end
    if (state_q == ST_WRAP) begin
      for (int k = 0; k < 3; k++) begin
        wrow_q.ang[k] <= wm_q[k] ? wrap_turn(pre_q[k]) : pre_q[k][19:0];
      end
      wrow_q.lo <= lo_q;
      wrow_q.hi <= hi_q;
    end
    if (state_q == ST_OUT) begin
      ang_out_q <= (jvld_q && axis_q != AXIS_NONE) ? rd_row.ang[axis_q] : '0;
      sel_out_q <= jvld_q && sel_q[row_q];
      chg_out_q <= chg_q;
    end
  end

  assign valid_o       = valid_q;
  assign angle_o       = ang_out_q;
  assign is_selected_o = sel_out_q;
  assign changed_o     = chg_out_q;

  a_strobe_after_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(state_q == ST_OUT))
    else $error("result strobe without output state");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("item accepted but block not busy");

  a_changed_slew_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && changed_o) |-> (mode_q == MODE_SLEW))
    else $error("changed flag outside slew place");

  a_walk_writes_selected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && mode_q == MODE_MOVE) |-> sel_q[cnt_q])
    else $error("move selected wrote an unselected joint");

  a_cnt_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, cnt_q} <= (IW + 1)'(JOINT_COUNT - 1)))
    else $error("walk counter past last joint");

endmodule
